// ===== hw/rtl/vrt_pkg.sv =====
// ----------------------------------------------------------------------------
// vrt_pkg: shared types and constants of the voxel ray traversal block
// Holds the default parameter values, the time codes and the sequencer states.
// ----------------------------------------------------------------------------
package vrt_pkg;

    localparam int MAX_VOXELS_DEF      = 64;
    localparam int COORD_FRAC_BITS_DEF = 8;

    localparam int COORD_W = 16;
    localparam int CELL_W  = 16;
    localparam int OUT_W   = 8;
    localparam int MAG_W   = 16;
    localparam int TIME_W  = 32;
    localparam int TIME_FRAC = 16;

    localparam logic [TIME_W-1:0] T_INF = 32'hFFFF_FFFF;
    localparam logic [TIME_W-1:0] T_SAT = 32'hFFFF_FFFE;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

// ===== hw/rtl/voxel_ray_traversal.sv =====
// ----------------------------------------------------------------------------
// voxel_ray_traversal: 3D DDA voxel walker for one ray segment per beat
// Sets up crossing times with a shared serial divider, then walks the cells.
// ----------------------------------------------------------------------------
// Usage. One input beat carries a ray segment (start and end point, signed
// fixed point with COORD_FRAC_BITS fraction bits). The block answers with one
// output beat per voxel cell that the segment passes through, in order; the
// final beat carries last_cell, and truncated as well when MAX_VOXELS cells
// were sent before the end cell was reached.
// Timing. After a beat is accepted, six divisions run one after another on a
// single restoring divider, one quotient bit per cycle. The first cell is then
// loaded into the output register, and then one cell leaves per cycle while
// the receiver does not stall. in_stall stays high from the cycle after
// acceptance until the last cell has been loaded into the output register.
// Stall. A stalled output beat holds; the walk pauses until it is taken.
// Reset. rst_n clears the sequencer and the output valid; no beat is pending.
// ----------------------------------------------------------------------------
module voxel_ray_traversal #(
    parameter int MAX_VOXELS      = vrt_pkg::MAX_VOXELS_DEF,
    parameter int COORD_FRAC_BITS = vrt_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [15:0]          start_x,
    input  logic signed [15:0]          start_y,
    input  logic signed [15:0]          start_z,
    input  logic signed [15:0]          end_x,
    input  logic signed [15:0]          end_y,
    input  logic signed [15:0]          end_z,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [7:0]           cell_x,
    output logic signed [7:0]           cell_y,
    output logic signed [7:0]           cell_z,
    output logic                        last_cell,
    output logic                        truncated
);

    // Dividend width: (|num| << 16) and 1 << (F + 16) both fit in F + 17 bits.
    localparam int DW    = COORD_FRAC_BITS + 17;
    localparam int BCW   = $clog2(DW);
    localparam int CNT_W = $clog2(MAX_VOXELS + 1);
    localparam int NUM_W = COORD_FRAC_BITS + 1;
    localparam int CW    = vrt_pkg::CELL_W;

    vrt_pkg::state_t state_reg, state_next;

    logic signed [CW-1:0]       cur_reg   [3];
    logic signed [CW-1:0]       tgt_reg   [3];
    logic [vrt_pkg::MAG_W-1:0]  mag_reg   [3];
    logic [NUM_W-1:0]           unum_reg  [3];
    logic [vrt_pkg::TIME_W-1:0] t_reg     [3];
    logic [vrt_pkg::TIME_W-1:0] inc_reg   [3];
    logic [2:0]                 neg_reg;
    logic [2:0]                 zero_reg;
    logic [2:0]                 pre_reg;
    logic                       first_reg;
    logic [CNT_W-1:0]           cnt_reg;

    // Serial divider state.
    logic [DW-1:0]              dvd_reg;
    logic [vrt_pkg::MAG_W:0]    rem_reg;
    logic [BCW-1:0]             bit_reg;
    logic [2:0]                 idx_reg;

    logic                       out_valid_reg;
    logic signed [7:0]          ox_reg, oy_reg, oz_reg;
    logic                       last_reg, trunc_reg;

    // Input decode at acceptance.
    logic signed [15:0]         s_in [3];
    logic signed [15:0]         e_in [3];
    logic signed [CW-1:0]       c_in [3];
    logic signed [CW-1:0]       t_in [3];
    logic signed [16:0]         d_in [3];
    logic [vrt_pkg::MAG_W-1:0]  m_in [3];
    logic [NUM_W-1:0]           u_in [3];
    logic signed [CW+COORD_FRAC_BITS+1:0] bnd  [3];
    logic signed [CW+COORD_FRAC_BITS+1:0] numv [3];

    logic accept, load_en, div_last, at_tgt, last_now;
    logic [1:0] ax;
    logic [vrt_pkg::MAG_W:0] rem_sh;
    logic [vrt_pkg::MAG_W:0] divisor;
    logic                    q_bit;
    logic [DW-1:0]           quo;
    logic [1:0]              div_axis;
    logic [vrt_pkg::TIME_W:0] tsum;
    logic [vrt_pkg::TIME_W-1:0] tnew;

    assign s_in[0] = start_x;
    assign s_in[1] = start_y;
    assign s_in[2] = start_z;
    assign e_in[0] = end_x;
    assign e_in[1] = end_y;
    assign e_in[2] = end_z;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            c_in[a] = s_in[a] >>> COORD_FRAC_BITS;
            t_in[a] = e_in[a] >>> COORD_FRAC_BITS;
            d_in[a] = 17'(e_in[a]) - 17'(s_in[a]);
            m_in[a] = d_in[a][16] ? 16'(-d_in[a]) : 16'(d_in[a]);
            bnd[a]  = (d_in[a][16]
                       ? ($signed((CW+COORD_FRAC_BITS+2)'(c_in[a]))
                          - $signed((CW+COORD_FRAC_BITS+2)'(1)))
                       : ($signed((CW+COORD_FRAC_BITS+2)'(c_in[a]))
                          + $signed((CW+COORD_FRAC_BITS+2)'(1))))
                      <<< COORD_FRAC_BITS;
            numv[a] = bnd[a] - (CW+COORD_FRAC_BITS+2)'(s_in[a]);
            u_in[a] = numv[a][CW+COORD_FRAC_BITS+1] ? NUM_W'(-numv[a]) : NUM_W'(numv[a]);
        end
    end

    assign accept  = in_valid && !in_stall;
    assign load_en = (state_reg == vrt_pkg::ST_EMIT) && (!out_valid_reg || !out_stall);

    // Divider step: one quotient bit per cycle.
    assign div_axis = idx_reg[2:1];
    assign divisor  = {1'b0, mag_reg[div_axis]};
    assign rem_sh   = {rem_reg[vrt_pkg::MAG_W-1:0], dvd_reg[DW-1]};
    assign q_bit    = (rem_sh >= divisor);
    assign quo      = {dvd_reg[DW-2:0], q_bit};
    assign div_last = (bit_reg == BCW'(DW - 1));

    // Walk: x only when strictly smallest, else y when below z, else z.
    always_comb
    begin
        if (t_reg[0] < t_reg[1])
            ax = (t_reg[0] < t_reg[2]) ? 2'd0 : 2'd2;
        else
            ax = (t_reg[1] < t_reg[2]) ? 2'd1 : 2'd2;
        tsum = {1'b0, t_reg[ax]} + {1'b0, inc_reg[ax]};
        if (t_reg[ax] == vrt_pkg::T_INF)
            tnew = vrt_pkg::T_INF;
        else if (tsum > {1'b0, vrt_pkg::T_SAT})
            tnew = vrt_pkg::T_SAT;
        else
            tnew = tsum[vrt_pkg::TIME_W-1:0];
    end

    assign at_tgt   = (cur_reg[0] == tgt_reg[0]) && (cur_reg[1] == tgt_reg[1]) &&
                      (cur_reg[2] == tgt_reg[2]);
    assign last_now = at_tgt || (cnt_reg == CNT_W'(MAX_VOXELS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vrt_pkg::ST_IDLE:
                if (accept)
                    state_next = vrt_pkg::ST_DIV;
            vrt_pkg::ST_DIV:
                if (div_last && idx_reg == 3'd5)
                    state_next = vrt_pkg::ST_EMIT;
            vrt_pkg::ST_EMIT:
                if (load_en && last_now)
                    state_next = vrt_pkg::ST_IDLE;
            default:
                state_next = vrt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            vrt_pkg::ST_IDLE: in_stall = 1'b0;
            default:          in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vrt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_en)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int a = 0; a < 3; a++)
            begin
                cur_reg[a]  <= c_in[a];
                tgt_reg[a]  <= t_in[a];
                mag_reg[a]  <= m_in[a];
                unum_reg[a] <= u_in[a];
                neg_reg[a]  <= d_in[a][16];
                zero_reg[a] <= (d_in[a] == 17'sd0);
                pre_reg[a]  <= d_in[a][16] && (c_in[a] != t_in[a]);
            end
            first_reg <= 1'b1;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            bit_reg   <= '0;
            rem_reg   <= '0;
            dvd_reg   <= DW'(u_in[0]) << vrt_pkg::TIME_FRAC;
        end
        else if (state_reg == vrt_pkg::ST_DIV)
        begin
            if (div_last)
            begin
                if (idx_reg[0])
                    inc_reg[div_axis] <= zero_reg[div_axis] ? vrt_pkg::T_INF
                                                            : vrt_pkg::TIME_W'(quo);
                else
                    t_reg[div_axis] <= zero_reg[div_axis] ? vrt_pkg::T_INF
                                                          : vrt_pkg::TIME_W'(quo);
                idx_reg <= idx_reg + 3'd1;
                bit_reg <= '0;
                rem_reg <= '0;
                // Even slots: first crossing time; odd slots: per-cell increment.
                if (idx_reg[0])
                    dvd_reg <= DW'(unum_reg[2'(idx_reg[2:1] + 2'd1)]) << vrt_pkg::TIME_FRAC;
                else
                    dvd_reg <= DW'(1) << (COORD_FRAC_BITS + vrt_pkg::TIME_FRAC);
            end
            else
            begin
                rem_reg <= q_bit ? (rem_sh - divisor) : rem_sh;
                dvd_reg <= quo;
                bit_reg <= bit_reg + BCW'(1);
            end
        end
        else if (load_en)
        begin
            ox_reg    <= cur_reg[0][7:0];
            oy_reg    <= cur_reg[1][7:0];
            oz_reg    <= cur_reg[2][7:0];
            last_reg  <= last_now;
            trunc_reg <= last_now && !at_tgt;
            cnt_reg   <= cnt_reg + CNT_W'(1);
            first_reg <= 1'b0;
            if (first_reg && (pre_reg != 3'b000))
            begin
                for (int a = 0; a < 3; a++)
                    if (pre_reg[a])
                        cur_reg[a] <= cur_reg[a] - CW'(1);
            end
            else
            begin
                cur_reg[ax] <= neg_reg[ax] ? (cur_reg[ax] - CW'(1)) : (cur_reg[ax] + CW'(1));
                t_reg[ax]   <= tnew;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign cell_x    = ox_reg;
    assign cell_y    = oy_reg;
    assign cell_z    = oz_reg;
    assign last_cell = last_reg;
    assign truncated = trunc_reg;

endmodule

// ===== bench/tb_voxel_ray_traversal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voxel_ray_traversal: self-checking bench for the voxel ray walker
// Drives ray segments with random gaps, stalls the cell stream at random, and
// compares every cell beat with the walk that a software model of the block
// predicts for the accepted ray.
// ----------------------------------------------------------------------------
module tb_voxel_ray_traversal;

    localparam int MAX_CELLS  = vrt_pkg::MAX_VOXELS_DEF;
    localparam int FRAC       = vrt_pkg::COORD_FRAC_BITS_DEF;
    localparam int N_RANDOM   = 252;
    localparam int CYCLE_CAP  = 4000000;

    // One cell beat as the block should send it.
    typedef struct packed {
        logic [7:0] cx;
        logic [7:0] cy;
        logic [7:0] cz;
        logic       last;
        logic       trunc;
    } cell_beat_t;

    // The scoreboard walks each accepted ray and keeps the cells still owed.
    class cell_scoreboard;
        cell_beat_t owed_cells[$];
        int         mismatches;

        function int floor_cell(int v);
            if (v >= 0)
                return v / (1 << FRAC);
            return -(((-v) + (1 << FRAC) - 1) / (1 << FRAC));
        endfunction

        function void note_ray(logic signed [15:0] s[3], logic signed [15:0] e[3]);
            int          cur[3];
            int          tgt[3];
            int          pre[3];
            logic [31:0] t_next[3];
            logic [31:0] t_inc[3];
            bit          neg[3];
            bit          neg_any;
            int          count;
            int          ax;
            int          delta;
            longint      num;
            longint      mag;
            longint      q;
            longint      sum;
            cell_beat_t  b;
            neg_any = 0;
            count = 0;
            for (int a = 0; a < 3; a++)
            begin
                delta = int'(e[a]) - int'(s[a]);
                cur[a] = floor_cell(s[a]);
                tgt[a] = floor_cell(e[a]);
                pre[a] = 0;
                neg[a] = 0;
                if (delta == 0)
                begin
                    t_next[a] = vrt_pkg::T_INF;
                    t_inc[a] = vrt_pkg::T_INF;
                end
                else
                begin
                    num = longint'(cur[a] + (delta > 0 ? 1 : -1)) * (1 << FRAC)
                          - longint'(s[a]);
                    if (num < 0)
                        num = -num;
                    mag = delta > 0 ? delta : -delta;
                    q = (num << 16) / mag;
                    t_next[a] = q > longint'(vrt_pkg::T_SAT) ? vrt_pkg::T_SAT : q[31:0];
                    q = (longint'(1) << (FRAC + 16)) / mag;
                    t_inc[a] = q[31:0];
                    if (delta < 0)
                    begin
                        neg[a] = 1;
                        if (cur[a] != tgt[a])
                        begin
                            pre[a] = -1;
                            neg_any = 1;
                        end
                    end
                end
            end
            b = '0;
            b.cx = cur[0][7:0]; b.cy = cur[1][7:0]; b.cz = cur[2][7:0];
            owed_cells.insert(owed_cells.size(), b);
            count = 1;
            // The pre-step for negative axes is sent straight after the start cell.
            if (neg_any)
            begin
                for (int a = 0; a < 3; a++)
                    cur[a] += pre[a];
                b.cx = cur[0][7:0]; b.cy = cur[1][7:0]; b.cz = cur[2][7:0];
                owed_cells.insert(owed_cells.size(), b);
                count++;
            end
            while (!(cur[0] == tgt[0] && cur[1] == tgt[1] && cur[2] == tgt[2])
                   && count < MAX_CELLS)
            begin
                // Ties go to y over x, and to z over both.
                if (t_next[0] < t_next[1])
                    ax = t_next[0] < t_next[2] ? 0 : 2;
                else
                    ax = t_next[1] < t_next[2] ? 1 : 2;
                cur[ax] += neg[ax] ? -1 : 1;
                if (t_next[ax] != vrt_pkg::T_INF)
                begin
                    sum = longint'(t_next[ax]) + longint'(t_inc[ax]);
                    t_next[ax] = sum > longint'(vrt_pkg::T_SAT) ? vrt_pkg::T_SAT : sum[31:0];
                end
                b.cx = cur[0][7:0]; b.cy = cur[1][7:0]; b.cz = cur[2][7:0];
                owed_cells.insert(owed_cells.size(), b);
                count++;
            end
            b = owed_cells[owed_cells.size() - 1];
            b.last = 1;
            b.trunc = !(cur[0] == tgt[0] && cur[1] == tgt[1] && cur[2] == tgt[2]);
            owed_cells[owed_cells.size() - 1] = b;
        endfunction

        function void check_cell(cell_beat_t got);
            cell_beat_t want;
            if (owed_cells.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected cell beat %h", got);
                return;
            end
            want = owed_cells.pop_front();
            if (want !== got)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("cell mismatch: expected x=%0d y=%0d z=%0d last=%b trunc=%b",
                             $signed(want.cx), $signed(want.cy), $signed(want.cz),
                             want.last, want.trunc);
                    $display("               got      x=%0d y=%0d z=%0d last=%b trunc=%b",
                             $signed(got.cx), $signed(got.cy), $signed(got.cz),
                             got.last, got.trunc);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [15:0] start_x, start_y, start_z, end_x, end_y, end_z;
    logic out_valid;
    logic out_stall;
    logic signed [7:0] cell_x, cell_y, cell_z;
    logic last_cell, truncated;

    cell_scoreboard board;
    int  cycles;
    bit  rays_done;
    bit  long_hold;

    voxel_ray_traversal uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .start_x(start_x), .start_y(start_y), .start_z(start_z),
        .end_x(end_x), .end_y(end_y), .end_z(end_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z),
        .last_cell(last_cell), .truncated(truncated)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Drives one ray: the gap first, then the beat is held until accepted.
    task automatic send_ray(logic signed [15:0] s[3], logic signed [15:0] e[3]);
        int gap;
        gap = $urandom_range(0, 18);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        start_x <= s[0]; start_y <= s[1]; start_z <= s[2];
        end_x <= e[0]; end_y <= e[1]; end_z <= e[2];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_ray(s, e);
    endtask

    // A coordinate near the start, so that most walks end before the limit.
    function automatic logic signed [15:0] near(logic signed [15:0] v);
        int span;
        span = 1 << $urandom_range(4, 12);
        return v + $signed(16'($urandom_range(0, 2 * span))) - 16'(span);
    endfunction

    task automatic send_directed();
        logic signed [15:0] s[3];
        logic signed [15:0] e[3];
        logic signed [15:0] ext[6];
        ext = '{16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0100, -16'sh0100};
        // Zero length, then single-axis rays in both directions.
        s = '{16'sh0080, 16'sh0080, 16'sh0080}; e = s;
        send_ray(s, e);
        for (int a = 0; a < 3; a++)
        begin
            s = '{16'sh0080, 16'sh0080, 16'sh0080}; e = s;
            e[a] = 16'sh0480;
            send_ray(s, e);
            e[a] = -16'sh0380;
            send_ray(s, e);
        end
        // Exact ties on the diagonal, negative diagonal and start on a boundary.
        s = '{16'sh0000, 16'sh0000, 16'sh0000}; e = '{16'sh0300, 16'sh0300, 16'sh0300};
        send_ray(s, e);
        send_ray(e, s);
        s = '{-16'sh0100, 16'sh0200, 16'sh0000}; e = '{16'sh0200, -16'sh0100, 16'sh0000};
        send_ray(s, e);
        // Extremes of every field: long rays that run into the cell limit.
        for (int i = 0; i < 6; i++)
        begin
            s = '{ext[i], ext[(i + 1) % 6], ext[(i + 2) % 6]};
            e = '{ext[(i + 3) % 6], ext[(i + 4) % 6], ext[(i + 5) % 6]};
            send_ray(s, e);
        end
        // Negative delta inside one cell: no pre-step.
        s = '{16'sh00F0, 16'sh0010, 16'sh0080}; e = '{16'sh0010, 16'sh0010, 16'sh0040};
        send_ray(s, e);
        // Full span on the x axis with the largest delta; y and z move by one LSB.
        s = '{-16'sh8000, 16'sh0000, 16'sh0000}; e = '{16'sh7FFF, 16'sh0001, -16'sh0001};
        send_ray(s, e);
    endtask

    initial
    begin
        logic signed [15:0] s[3];
        logic signed [15:0] e[3];
        board = new();
        rst_n = 0;
        in_valid = 0;
        start_x = 0; start_y = 0; start_z = 0;
        end_x = 0; end_y = 0; end_z = 0;
        rays_done = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_directed();
        for (int i = 0; i < N_RANDOM; i++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                s[a] = 16'($urandom);
                // Mostly short segments; some end anywhere in the whole range.
                e[a] = ($urandom_range(0, 7) == 0) ? 16'($urandom) : near(s[a]);
                if ($urandom_range(0, 9) == 0)
                    e[a] = s[a];
            end
            send_ray(s, e);
        end
        in_valid <= 0;
        rays_done = 1;
    end

    // The receiver stalls at random, with one long hold-off once more than four cells are owed.
    initial
    begin
        int hold;
        out_stall = 1;
        long_hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!long_hold && board.owed_cells.size() > 4)
            begin
                long_hold = 1;
                out_stall <= 1;
                repeat (600) @(posedge clk);
            end
            hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
            if (hold > 0)
            begin
                out_stall <= 1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 0;
        end
    end

    // Accepted cell beats are checked against the oldest owed cell.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_cell({cell_x, cell_y, cell_z, last_cell, truncated});
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_CAP)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        wait (rays_done);
        while (board.owed_cells.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.mismatches == 0 && board.owed_cells.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
